// ===== hdl/stcd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stcd_pkg
// Shared constants, codes and types of the SCSI target CDB decoder.
// ----------------------------------------------------------------------------
package stcd_pkg;

    localparam int NUM_IDS  = 8;
    localparam int NUM_LUNS = 2;

    localparam logic [3:0] CDB_MAX  = 4'd12;
    localparam int         CDB_KEPT = 9;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_QUIRK = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MASK  = 2'd1;

    localparam logic [1:0] QUIRK_VENDOR = 2'd1;

    localparam logic [3:0] KIND_NODATA   = 4'd0;
    localparam logic [3:0] KIND_SENSE    = 4'd1;
    localparam logic [3:0] KIND_READ     = 4'd2;
    localparam logic [3:0] KIND_WRITE    = 4'd3;
    localparam logic [3:0] KIND_INQUIRY  = 4'd4;
    localparam logic [3:0] KIND_MODESNS  = 4'd5;
    localparam logic [3:0] KIND_CAPACITY = 4'd6;
    localparam logic [3:0] KIND_DRVPARAM = 4'd7;
    localparam logic [3:0] KIND_UNSUPP   = 4'd8;

    localparam logic [7:0] OP_TEST_READY  = 8'h00;
    localparam logic [7:0] OP_REZERO      = 8'h01;
    localparam logic [7:0] OP_REQ_SENSE   = 8'h03;
    localparam logic [7:0] OP_FORMAT      = 8'h04;
    localparam logic [7:0] OP_VERIFY6     = 8'h06;
    localparam logic [7:0] OP_REASSIGN    = 8'h07;
    localparam logic [7:0] OP_READ6       = 8'h08;
    localparam logic [7:0] OP_WRITE6      = 8'h0A;
    localparam logic [7:0] OP_SEEK6       = 8'h0B;
    localparam logic [7:0] OP_INQUIRY     = 8'h12;
    localparam logic [7:0] OP_MODE_SNS6   = 8'h1A;
    localparam logic [7:0] OP_START_STOP  = 8'h1B;
    localparam logic [7:0] OP_MEDIUM_LOCK = 8'h1E;
    localparam logic [7:0] OP_READ_CAP    = 8'h25;
    localparam logic [7:0] OP_READ10      = 8'h28;
    localparam logic [7:0] OP_WRITE10     = 8'h2A;
    localparam logic [7:0] OP_SEEK10      = 8'h2B;
    localparam logic [7:0] OP_MODE_SNS10  = 8'h5A;
    localparam logic [7:0] OP_DRV_PARAM   = 8'hC2;

    localparam logic [3:0] SENSE_NONE    = 4'h0;
    localparam logic [3:0] SENSE_ILLEGAL = 4'h5;
    localparam logic [7:0] STATUS_CHECK  = 8'h02;

    typedef struct packed {
        logic                     last;
        logic [3:0]               length;
        logic [2:0]               target;
        logic [CDB_KEPT-1:0][7:0] bytes;
    } t_frame;

    typedef struct packed {
        logic [3:0]  command_kind;
        logic [2:0]  lun;
        logic [31:0] block_address;
        logic [16:0] block_count;
        logic [15:0] alloc_length;
        logic [7:0]  status_byte;
        logic [3:0]  sense_reported;
        logic [3:0]  cdb_length;
    } t_result;

    function automatic logic [3:0] group_len(input logic [2:0] grp);
        logic [3:0] len;
        case (grp)
            3'd1, 3'd2: len = 4'd10;
            3'd5:       len = 4'd12;
            default:    len = 4'd6;
        endcase
        return len;
    endfunction

endpackage

// ===== hdl/stcd_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stcd_in_if
// Command byte channel: one bus byte or bus reset per item.
// ----------------------------------------------------------------------------
interface stcd_in_if;
    logic       valid;
    logic       ready;
    logic       action;
    logic [7:0] data_byte;
    logic [2:0] target_id;

    modport source (output valid, output action, output data_byte, output target_id,
                    input ready);
    modport sink   (input valid, input action, input data_byte, input target_id,
                    output ready);
endinterface

// ===== hdl/stcd_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stcd_out_if
// Decoded command channel: one item per completed CDB.
// ----------------------------------------------------------------------------
interface stcd_out_if;
    logic        valid;
    logic        ready;
    logic [3:0]  command_kind;
    logic [2:0]  lun;
    logic [31:0] block_address;
    logic [16:0] block_count;
    logic [15:0] alloc_length;
    logic [7:0]  status_byte;
    logic [3:0]  sense_reported;
    logic [3:0]  cdb_length;

    modport source (output valid, output command_kind, output lun, output block_address,
                    output block_count, output alloc_length, output status_byte,
                    output sense_reported, output cdb_length, input ready);
    modport sink   (input valid, input command_kind, input lun, input block_address,
                    input block_count, input alloc_length, input status_byte,
                    input sense_reported, input cdb_length, output ready);
endinterface

// ===== hdl/stcd_collect.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stcd_collect
// Input register and CDB byte collection: length from the group code,
// target latch and byte store; flags the last byte of a command.
// ----------------------------------------------------------------------------
module stcd_collect (
    input  logic             i_clk,
    input  logic             i_rst_n,
    stcd_in_if.sink          i_cmd,
    input  logic             i_adv,
    output logic             o_pending,
    output stcd_pkg::t_frame o_frame
);

    logic       r_in_vld;
    logic       r_in_act;
    logic [7:0] r_in_byte;
    logic [2:0] r_in_tgt;

    logic [3:0] r_idx, n_idx;
    logic [3:0] r_exp;
    logic [2:0] r_tgt;
    logic [7:0] r_store [stcd_pkg::CDB_KEPT];

    logic       w_accept;
    logic [3:0] w_idx;
    logic       w_first;
    logic [3:0] w_exp;
    logic [2:0] w_tgt;
    logic [3:0] w_idx_inc;
    logic       w_last;

    assign i_cmd.ready = !r_in_vld || i_adv;
    assign w_accept    = i_cmd.valid && i_cmd.ready;
    assign o_pending   = r_in_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (w_accept) begin
            r_in_vld <= 1'b1;
        end else if (i_adv) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in_act  <= i_cmd.action;
            r_in_byte <= i_cmd.data_byte;
            r_in_tgt  <= i_cmd.target_id;
        end
    end

    always_comb begin
        w_idx     = (r_idx >= stcd_pkg::CDB_MAX) ? 4'd0 : r_idx;
        w_first   = (w_idx == 4'd0);
        w_exp     = w_first ? stcd_pkg::group_len(r_in_byte[7:5]) : r_exp;
        w_tgt     = w_first ? r_in_tgt : r_tgt;
        w_idx_inc = w_idx + 4'd1;
        w_last    = (w_idx_inc >= w_exp);
        if (r_in_act) begin
            n_idx = 4'd0;
        end else if (w_last) begin
            n_idx = 4'd0;
        end else begin
            n_idx = w_idx_inc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= 4'd0;
            r_exp <= 4'd0;
            r_tgt <= 3'd0;
        end else if (i_adv) begin
            r_idx <= n_idx;
            if (!r_in_act) begin
                r_exp <= w_exp;
                r_tgt <= w_tgt;
            end
        end
    end

    // bytes beyond the ninth never reach the decode
    always_ff @(posedge i_clk) begin
        if (i_adv && !r_in_act && (w_idx < 4'(stcd_pkg::CDB_KEPT))) begin
            r_store[w_idx] <= r_in_byte;
        end
    end

    always_comb begin
        o_frame.last   = !r_in_act && w_last;
        o_frame.length = w_exp;
        o_frame.target = w_tgt;
        for (int i = 0; i < stcd_pkg::CDB_KEPT; i++) begin
            o_frame.bytes[i] = (w_idx == 4'(i)) ? r_in_byte : r_store[i];
        end
    end

endmodule

// ===== hdl/stcd_decode.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stcd_decode
// Opcode decode, field extraction, image check and the persistent
// sense key.
// ----------------------------------------------------------------------------
module stcd_decode (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_adv,
    input  stcd_pkg::t_frame  i_frame,
    input  logic [1:0]        i_quirk,
    input  logic [15:0]       i_mask,
    output stcd_pkg::t_result o_res
);

    logic [3:0]  r_sense, n_sense;

    logic [7:0]  w_c0, w_c1, w_c2, w_c3, w_c4, w_c5, w_c7, w_c8;
    logic [2:0]  w_lun;
    logic [31:0] w_addr6, w_addr10;
    logic [16:0] w_cnt6;
    logic [15:0] w_len10;
    logic [5:0]  w_bit;
    logic        w_img_ok;
    logic        w_need_img;
    logic        w_check;

    assign w_c0 = i_frame.bytes[0];
    assign w_c1 = i_frame.bytes[1];
    assign w_c2 = i_frame.bytes[2];
    assign w_c3 = i_frame.bytes[3];
    assign w_c4 = i_frame.bytes[4];
    assign w_c5 = i_frame.bytes[5];
    assign w_c7 = i_frame.bytes[7];
    assign w_c8 = i_frame.bytes[8];

    assign w_lun    = w_c1[7:5];
    assign w_addr6  = {11'd0, w_c1[4:0], w_c2, w_c3};
    assign w_cnt6   = (w_c4 == 8'd0) ? 17'h100 : {9'd0, w_c4};
    assign w_addr10 = {w_c2, w_c3, w_c4, w_c5};
    assign w_len10  = {w_c7, w_c8};

    assign w_bit    = 6'(i_frame.target) * 6'(stcd_pkg::NUM_LUNS) + 6'(w_lun);
    assign w_img_ok = ({1'b0, i_frame.target} < 4'(stcd_pkg::NUM_IDS))
                   && ({1'b0, w_lun} < 4'(stcd_pkg::NUM_LUNS))
                   && (w_bit < 6'd16)
                   && i_mask[w_bit[3:0]];

    always_comb begin
        o_res.command_kind   = stcd_pkg::KIND_UNSUPP;
        o_res.block_address  = 32'd0;
        o_res.block_count    = 17'd0;
        o_res.alloc_length   = 16'd0;
        o_res.sense_reported = stcd_pkg::SENSE_NONE;
        n_sense              = r_sense;
        w_need_img           = 1'b0;
        w_check              = 1'b0;
        case (w_c0) inside
            stcd_pkg::OP_TEST_READY, stcd_pkg::OP_REZERO, stcd_pkg::OP_FORMAT,
            stcd_pkg::OP_VERIFY6, stcd_pkg::OP_REASSIGN, stcd_pkg::OP_SEEK6,
            stcd_pkg::OP_START_STOP, stcd_pkg::OP_MEDIUM_LOCK, stcd_pkg::OP_SEEK10: begin
                o_res.command_kind = stcd_pkg::KIND_NODATA;
            end
            stcd_pkg::OP_REQ_SENSE: begin
                o_res.command_kind   = stcd_pkg::KIND_SENSE;
                o_res.alloc_length   = {8'd0, w_c4};
                o_res.sense_reported = r_sense;
                n_sense              = stcd_pkg::SENSE_NONE;
            end
            stcd_pkg::OP_READ6, stcd_pkg::OP_WRITE6: begin
                o_res.command_kind  = (w_c0 == stcd_pkg::OP_READ6) ?
                                      stcd_pkg::KIND_READ : stcd_pkg::KIND_WRITE;
                o_res.block_address = w_addr6;
                o_res.block_count   = w_cnt6;
                w_need_img          = 1'b1;
            end
            stcd_pkg::OP_READ10, stcd_pkg::OP_WRITE10: begin
                o_res.command_kind  = (w_c0 == stcd_pkg::OP_READ10) ?
                                      stcd_pkg::KIND_READ : stcd_pkg::KIND_WRITE;
                o_res.block_address = w_addr10;
                o_res.block_count   = {1'b0, w_len10};
                w_need_img          = 1'b1;
            end
            stcd_pkg::OP_INQUIRY: begin
                o_res.command_kind = stcd_pkg::KIND_INQUIRY;
                o_res.alloc_length = {8'd0, w_c4};
            end
            stcd_pkg::OP_MODE_SNS6: begin
                o_res.command_kind = stcd_pkg::KIND_MODESNS;
                o_res.alloc_length = {8'd0, w_c4};
                w_need_img         = 1'b1;
            end
            stcd_pkg::OP_MODE_SNS10: begin
                o_res.command_kind = stcd_pkg::KIND_MODESNS;
                o_res.alloc_length = w_len10;
                w_need_img         = 1'b1;
            end
            stcd_pkg::OP_READ_CAP: begin
                o_res.command_kind = stcd_pkg::KIND_CAPACITY;
                w_need_img         = 1'b1;
            end
            stcd_pkg::OP_DRV_PARAM: begin
                if (i_quirk == stcd_pkg::QUIRK_VENDOR) begin
                    o_res.command_kind = stcd_pkg::KIND_DRVPARAM;
                end else begin
                    w_check = 1'b1;
                    n_sense = stcd_pkg::SENSE_ILLEGAL;
                end
            end
            default: begin
                w_check = 1'b1;
                n_sense = stcd_pkg::SENSE_ILLEGAL;
            end
        endcase
        if (w_need_img && !w_img_ok) begin
            w_check = 1'b1;
        end
        o_res.lun         = w_lun;
        o_res.status_byte = {w_lun, 5'd0} | (w_check ? stcd_pkg::STATUS_CHECK : 8'd0);
        o_res.cdb_length  = i_frame.length;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sense <= stcd_pkg::SENSE_NONE;
        end else if (i_adv && i_frame.last) begin
            r_sense <= n_sense;
        end
    end

endmodule

// ===== hdl/scsi_target_cdb_decoder_top.sv =====
// SCSI target CDB decoder. Takes one command byte (or a bus reset) per item
// on i_cmd and returns one decoded command on o_res after the last byte of
// each 6, 10 or 12 byte CDB. One item is accepted every cycle, except while
// the last byte of a command is held as below. The path is the input
// register, then decode into the result register. While a decoded command
// waits on o_res, further bytes are still taken. Only the last byte of the
// next command is held, with the input stalled behind it, until the waiting
// result is taken. quirk_mode and image_present_mask are to be written
// through i_cfg_* only while the block is idle; the block itself does not
// enforce this.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scsi_target_cdb_decoder_top
// Top level: configuration registers, stage control and result register.
// ----------------------------------------------------------------------------
module scsi_target_cdb_decoder_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    stcd_in_if.sink                            i_cmd,
    stcd_out_if.source                         o_res,
    input  logic                               i_cfg_we,
    input  logic [stcd_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [stcd_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    logic [1:0]        r_quirk;
    logic [15:0]       r_mask;
    logic              r_out_vld;
    stcd_pkg::t_result r_res;

    logic              w_pending;
    logic              w_adv;
    stcd_pkg::t_frame  w_frame;
    stcd_pkg::t_result w_res;

    // only the last byte of a command needs room in the result register
    assign w_adv = w_pending && (!w_frame.last || !r_out_vld || o_res.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quirk <= 2'd0;
            r_mask  <= 16'd0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                stcd_pkg::CFG_QUIRK: r_quirk <= i_cfg_data[1:0];
                stcd_pkg::CFG_MASK:  r_mask  <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    stcd_collect u_collect (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (i_cmd),
        .i_adv     (w_adv),
        .o_pending (w_pending),
        .o_frame   (w_frame)
    );

    stcd_decode u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_frame (w_frame),
        .i_quirk (r_quirk),
        .i_mask  (r_mask),
        .o_res   (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_adv && w_frame.last) begin
            r_out_vld <= 1'b1;
        end else if (o_res.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && w_frame.last) begin
            r_res <= w_res;
        end
    end

    assign o_res.valid          = r_out_vld;
    assign o_res.command_kind   = r_res.command_kind;
    assign o_res.lun            = r_res.lun;
    assign o_res.block_address  = r_res.block_address;
    assign o_res.block_count    = r_res.block_count;
    assign o_res.alloc_length   = r_res.alloc_length;
    assign o_res.status_byte    = r_res.status_byte;
    assign o_res.sense_reported = r_res.sense_reported;
    assign o_res.cdb_length     = r_res.cdb_length;

endmodule

// ===== hdl/stcd_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stcd_checker
// Port-level checks on the decoder, bound to the top level.
// ----------------------------------------------------------------------------
module stcd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [3:0]  i_kind,
    input logic [7:0]  i_status,
    input logic [3:0]  i_sense,
    input logic [3:0]  i_length
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_kind)
                                        && $stable(i_status) && $stable(i_length))
        else $error("stalled item changed");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("item shown after reset");

    a_length_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_length == 4'd6) || (i_length == 4'd10) || (i_length == 4'd12))
        else $error("bad cdb length");

    a_sense_only_on_rs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_sense != stcd_pkg::SENSE_NONE) |-> i_kind == stcd_pkg::KIND_SENSE)
        else $error("sense reported outside request sense");

    a_unsupp_checks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_kind == stcd_pkg::KIND_UNSUPP) |-> i_status[1])
        else $error("unsupported command without check condition");

endmodule

bind scsi_target_cdb_decoder_top stcd_checker u_stcd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_kind      (o_res.command_kind),
    .i_status    (o_res.status_byte),
    .i_sense     (o_res.sense_reported),
    .i_length    (o_res.cdb_length)
);

// ===== sim/scsi_target_cdb_decoder_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scsi_target_cdb_decoder_top_tb
// Self-checking bench for the SCSI target CDB decoder. Command bytes, whole
// CDBs of every opcode and random content, and bus resets are sent through
// the command channel with random gaps, and the result channel is stalled at
// random. A scoreboard decodes each completed CDB on its own and compares
// every field of each returned command against it, in order.
// ----------------------------------------------------------------------------
module scsi_target_cdb_decoder_top_tb;
    import stcd_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int TARGET_ITEMS   = 950;
    localparam int PHASE_ITEMS    = 120;

    localparam logic [7:0] KNOWN_OPS [19] = '{
        OP_TEST_READY, OP_REZERO, OP_REQ_SENSE, OP_FORMAT, OP_VERIFY6, OP_REASSIGN,
        OP_READ6, OP_WRITE6, OP_SEEK6, OP_INQUIRY, OP_MODE_SNS6, OP_START_STOP,
        OP_MEDIUM_LOCK, OP_READ_CAP, OP_READ10, OP_WRITE10, OP_SEEK10, OP_MODE_SNS10,
        OP_DRV_PARAM
    };
    localparam logic [7:0] NODATA_OPS [9] = '{
        OP_TEST_READY, OP_REZERO, OP_FORMAT, OP_VERIFY6, OP_REASSIGN, OP_SEEK6,
        OP_START_STOP, OP_MEDIUM_LOCK, OP_SEEK10
    };

    class cdb_scoreboard;
        logic [1:0]  quirk;
        logic [15:0] image_mask;
        logic [3:0]  byte_pos;
        logic [3:0]  cdb_len;
        logic [3:0]  sense_key;
        logic [2:0]  target;
        logic [7:0]  cdb [12];
        t_result     expected_cmds [$];
        int          n_errors;

        function new();
            quirk      = '0;
            image_mask = '0;
            byte_pos   = '0;
            cdb_len    = '0;
            sense_key  = SENSE_NONE;
            target     = '0;
            n_errors   = 0;
            foreach (cdb[i]) cdb[i] = '0;
        endfunction

        static function logic [3:0] len_of(logic [7:0] op);
            case (op[7:5])
                3'd1, 3'd2: return 4'd10;
                3'd5:       return 4'd12;
                default:    return 4'd6;
            endcase
        endfunction

        function void report_error(string msg);
            $display("MISMATCH at %0t: %s", $time, msg);
            n_errors++;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] sel, logic [CFG_DATA_W-1:0] v);
            if (sel == CFG_QUIRK) quirk = v[1:0];
            else if (sel == CFG_MASK) image_mask = v;
        endfunction

        function int outstanding();
            return expected_cmds.size();
        endfunction

        function void decode_cdb();
            t_result    e;
            logic [2:0] lun;
            logic       need_img;
            logic       chk;
            int         bitn;
            e = '0;
            lun = cdb[1][7:5];
            need_img = 1'b0;
            chk = 1'b0;
            e.command_kind = KIND_UNSUPP;
            case (cdb[0])
                OP_TEST_READY, OP_REZERO, OP_FORMAT, OP_VERIFY6, OP_REASSIGN,
                OP_SEEK6, OP_START_STOP, OP_MEDIUM_LOCK, OP_SEEK10: begin
                    e.command_kind = KIND_NODATA;
                end
                OP_REQ_SENSE: begin
                    e.command_kind = KIND_SENSE;
                    e.alloc_length = {8'd0, cdb[4]};
                    e.sense_reported = sense_key;
                    sense_key = SENSE_NONE;
                end
                OP_READ6, OP_WRITE6: begin
                    e.command_kind = (cdb[0] == OP_READ6) ? KIND_READ : KIND_WRITE;
                    e.block_address = {11'd0, cdb[1][4:0], cdb[2], cdb[3]};
                    e.block_count = (cdb[4] == 8'd0) ? 17'h100 : {9'd0, cdb[4]};
                    need_img = 1'b1;
                end
                OP_READ10, OP_WRITE10: begin
                    e.command_kind = (cdb[0] == OP_READ10) ? KIND_READ : KIND_WRITE;
                    e.block_address = {cdb[2], cdb[3], cdb[4], cdb[5]};
                    e.block_count = {1'b0, cdb[7], cdb[8]};
                    need_img = 1'b1;
                end
                OP_INQUIRY: begin
                    e.command_kind = KIND_INQUIRY;
                    e.alloc_length = {8'd0, cdb[4]};
                end
                OP_MODE_SNS6: begin
                    e.command_kind = KIND_MODESNS;
                    e.alloc_length = {8'd0, cdb[4]};
                    need_img = 1'b1;
                end
                OP_MODE_SNS10: begin
                    e.command_kind = KIND_MODESNS;
                    e.alloc_length = {cdb[7], cdb[8]};
                    need_img = 1'b1;
                end
                OP_READ_CAP: begin
                    e.command_kind = KIND_CAPACITY;
                    need_img = 1'b1;
                end
                OP_DRV_PARAM: begin
                    if (quirk == QUIRK_VENDOR) begin
                        e.command_kind = KIND_DRVPARAM;
                    end else begin
                        chk = 1'b1;
                        sense_key = SENSE_ILLEGAL;
                    end
                end
                default: begin
                    chk = 1'b1;
                    sense_key = SENSE_ILLEGAL;
                end
            endcase
            if (need_img) begin
                bitn = int'(target) * NUM_LUNS + int'(lun);
                if (int'(target) >= NUM_IDS || int'(lun) >= NUM_LUNS || bitn >= 16) begin
                    chk = 1'b1;
                end else if (!image_mask[bitn]) begin
                    chk = 1'b1;
                end
            end
            e.lun = lun;
            e.status_byte = {lun, 5'd0} | (chk ? STATUS_CHECK : 8'd0);
            e.cdb_length = cdb_len;
            expected_cmds.push_back(e);
        endfunction

        function void accept_byte(logic act, logic [7:0] b, logic [2:0] tid);
            if (act) begin
                byte_pos = '0;
                return;
            end
            if (byte_pos >= CDB_MAX) byte_pos = '0;
            if (byte_pos == 4'd0) begin
                cdb_len = len_of(b);
                target = tid;
            end
            cdb[byte_pos] = b;
            byte_pos++;
            if (byte_pos >= cdb_len) begin
                byte_pos = '0;
                decode_cdb();
            end
        endfunction

        function void cmp_field(string name, logic [31:0] got, logic [31:0] want);
            if (got !== want)
                report_error($sformatf("%s got %0h expected %0h", name, got, want));
        endfunction

        function void check_command(t_result got);
            t_result w;
            if (expected_cmds.size() == 0) begin
                report_error($sformatf("unexpected command, kind %0d", got.command_kind));
                return;
            end
            w = expected_cmds.pop_front();
            cmp_field("command_kind", 32'(got.command_kind), 32'(w.command_kind));
            cmp_field("lun", 32'(got.lun), 32'(w.lun));
            cmp_field("block_address", got.block_address, w.block_address);
            cmp_field("block_count", 32'(got.block_count), 32'(w.block_count));
            cmp_field("alloc_length", 32'(got.alloc_length), 32'(w.alloc_length));
            cmp_field("status_byte", 32'(got.status_byte), 32'(w.status_byte));
            cmp_field("sense_reported", 32'(got.sense_reported), 32'(w.sense_reported));
            cmp_field("cdb_length", 32'(got.cdb_length), 32'(w.cdb_length));
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    stcd_in_if  cmd_if();
    stcd_out_if res_if();

    scsi_target_cdb_decoder_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd_if),
        .o_res      (res_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    cdb_scoreboard sb;
    int      n_items;
    int      idle_cycles;
    int      stall_left;
    bit      tx_idle_en;
    bit      rx_stall_en;
    t_result seen;

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // mostly short gaps, now and then a long one
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            res_if.ready <= 1'b0;
            stall_left = stall_left - 1;
        end else if (rx_stall_en && $urandom_range(0, 3) == 0) begin
            res_if.ready <= 1'b0;
            stall_left = gap_len() - 1;
        end else begin
            res_if.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (res_if.valid && res_if.ready) begin
                seen.command_kind   = res_if.command_kind;
                seen.lun            = res_if.lun;
                seen.block_address  = res_if.block_address;
                seen.block_count    = res_if.block_count;
                seen.alloc_length   = res_if.alloc_length;
                seen.status_byte    = res_if.status_byte;
                seen.sense_reported = res_if.sense_reported;
                seen.cdb_length     = res_if.cdb_length;
                sb.check_command(seen);
            end
            if (cmd_if.valid && cmd_if.ready) begin
                sb.accept_byte(cmd_if.action, cmd_if.data_byte, cmd_if.target_id);
                n_items++;
            end
        end
    end

    always @(posedge i_clk) begin
        if ((cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic send_item(input logic act, input logic [7:0] b, input logic [2:0] tid);
        int gap;
        gap = 0;
        if (tx_idle_en && $urandom_range(0, 99) >= 55) gap = gap_len();
        if (gap > 0) begin
            cmd_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        cmd_if.valid     <= 1'b1;
        cmd_if.action    <= act;
        cmd_if.data_byte <= b;
        cmd_if.target_id <= tid;
        @(posedge i_clk);
        while (!cmd_if.ready) @(posedge i_clk);
    endtask

    // sends the first stop bytes of a CDB; a bus reset follows if cut short
    task automatic issue_cdb(input logic [7:0] op, input logic [2:0] lun,
                             input logic [31:0] lba, input logic [15:0] cnt,
                             input logic [2:0] tid, input int stop);
        logic [7:0] b [12];
        int         len;
        len = int'(cdb_scoreboard::len_of(op));
        foreach (b[i]) b[i] = 8'($urandom);
        b[0] = op;
        if (len == 6) begin
            b[1] = {lun, lba[20:16]};
            b[2] = lba[15:8];
            b[3] = lba[7:0];
            b[4] = cnt[7:0];
        end else begin
            b[1][7:5] = lun;
            b[2] = lba[31:24];
            b[3] = lba[23:16];
            b[4] = lba[15:8];
            b[5] = lba[7:0];
            b[7] = cnt[15:8];
            b[8] = cnt[7:0];
        end
        for (int i = 0; i < len && i < stop; i++)
            send_item(1'b0, b[i], (i == 0) ? tid : 3'($urandom_range(0, 7)));
        if (stop < len)
            send_item(1'b1, 8'($urandom), 3'($urandom_range(0, 7)));
    endtask

    task automatic random_cmd();
        logic [7:0]  op;
        logic [2:0]  lun;
        logic [31:0] lba;
        logic [15:0] cnt;
        int          len;
        int          stop;
        int          r;
        r = $urandom_range(0, 99);
        op = (r < 82) ? KNOWN_OPS[$urandom_range(0, 18)] : 8'($urandom);
        lun = ($urandom_range(0, 3) != 0) ? 3'($urandom_range(0, 1)) : 3'($urandom);
        r = $urandom_range(0, 9);
        lba = (r == 0) ? 32'd0 : (r == 1) ? 32'hFFFF_FFFF : 32'($urandom);
        r = $urandom_range(0, 9);
        cnt = (r == 0) ? 16'd0 : (r == 1) ? 16'hFFFF : 16'($urandom);
        len = int'(cdb_scoreboard::len_of(op));
        stop = ($urandom_range(0, 99) < 7) ? $urandom_range(0, len - 1) : len;
        issue_cdb(op, lun, lba, cnt, 3'($urandom_range(0, 7)), stop);
    endtask

    task automatic settle();
        cmd_if.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.outstanding() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_regs(input logic [1:0] quirk, input logic [15:0] mask);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_QUIRK;
        i_cfg_data <= {14'd0, quirk};
        @(posedge i_clk);
        i_cfg_idx  <= CFG_MASK;
        i_cfg_data <= mask;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        sb.set_reg(CFG_QUIRK, {14'd0, quirk});
        sb.set_reg(CFG_MASK, mask);
    endtask

    initial begin
        int         phase;
        int         phase_end;
        logic [1:0] q;
        logic [15:0] m;
        sb = new();
        n_items = 0;
        idle_cycles = 0;
        stall_left = 0;
        tx_idle_en = 1'b1;
        rx_stall_en = 1'b1;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        cmd_if.valid = 1'b0;
        cmd_if.action = 1'b0;
        cmd_if.data_byte = '0;
        cmd_if.target_id = '0;
        res_if.ready = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset defaults: standard quirk, no images
        issue_cdb(OP_REQ_SENSE, 3'd0, 32'd0, 16'h00FF, 3'd0, 12);
        issue_cdb(OP_READ6, 3'd0, 32'd5, 16'd1, 3'd0, 12);
        issue_cdb(8'hFF, 3'd7, 32'd0, 16'd0, 3'd7, 12);
        issue_cdb(OP_REQ_SENSE, 3'd0, 32'd0, 16'h0000, 3'd0, 12);
        issue_cdb(OP_REQ_SENSE, 3'd1, 32'd0, 16'h0012, 3'd3, 12);
        issue_cdb(OP_DRV_PARAM, 3'd0, 32'd0, 16'd0, 3'd0, 12);
        settle();
        set_regs(QUIRK_VENDOR, 16'hFFFF);
        issue_cdb(OP_DRV_PARAM, 3'd1, 32'd0, 16'd0, 3'd5, 12);
        issue_cdb(OP_READ6, 3'd1, 32'h001F_FFFF, 16'd0, 3'd7, 12);
        issue_cdb(OP_WRITE6, 3'd0, 32'd0, 16'h00FF, 3'd7, 12);
        issue_cdb(OP_READ10, 3'd0, 32'hFFFF_FFFF, 16'hFFFF, 3'd2, 12);
        issue_cdb(OP_WRITE10, 3'd1, 32'd0, 16'd0, 3'd4, 12);
        issue_cdb(OP_INQUIRY, 3'd6, 32'd0, 16'h00FF, 3'd1, 12);
        issue_cdb(OP_MODE_SNS6, 3'd0, 32'd0, 16'h0024, 3'd6, 12);
        issue_cdb(OP_MODE_SNS10, 3'd1, 32'd0, 16'hFFFF, 3'd6, 12);
        issue_cdb(OP_READ_CAP, 3'd7, 32'd0, 16'd0, 3'd0, 12);
        foreach (NODATA_OPS[i])
            issue_cdb(NODATA_OPS[i], 3'($urandom), 32'($urandom), 16'($urandom),
                      3'($urandom_range(0, 7)), 12);
        // unknown opcodes of every length group
        issue_cdb(8'hA0, 3'd0, 32'd0, 16'd0, 3'd0, 12);
        issue_cdb(8'h40, 3'd0, 32'd0, 16'd0, 3'd0, 12);
        issue_cdb(8'h60, 3'd0, 32'd0, 16'd0, 3'd0, 12);
        issue_cdb(8'h80, 3'd0, 32'd0, 16'd0, 3'd0, 12);
        issue_cdb(8'hE0, 3'd0, 32'd0, 16'd0, 3'd0, 12);
        // bus reset mid-command and while idle; sense key survives both
        issue_cdb(OP_READ10, 3'd0, 32'd1, 16'd1, 3'd0, 4);
        issue_cdb(OP_TEST_READY, 3'd0, 32'd0, 16'd0, 3'd0, 0);
        issue_cdb(OP_REQ_SENSE, 3'd0, 32'd0, 16'h0004, 3'd0, 12);
        settle();
        set_regs(2'd2, 16'h0001);
        issue_cdb(OP_DRV_PARAM, 3'd0, 32'd0, 16'd0, 3'd0, 12);
        issue_cdb(OP_READ6, 3'd0, 32'd9, 16'd3, 3'd0, 12);
        issue_cdb(OP_READ6, 3'd1, 32'd9, 16'd3, 3'd0, 12);

        phase = 0;
        while (n_items < TARGET_ITEMS) begin
            case (phase % 5)
                0:       begin q = 2'd0;         m = 16'hFFFF;      end
                1:       begin q = QUIRK_VENDOR; m = 16'h0000;      end
                2:       begin q = 2'd2;         m = 16'($urandom); end
                3:       begin q = QUIRK_VENDOR; m = 16'hFFFF;      end
                default: begin q = 2'($urandom_range(0, 2)); m = 16'($urandom); end
            endcase
            settle();
            tx_idle_en  = (phase % 3) != 2;
            rx_stall_en = (phase % 4) != 3;
            set_regs(q, m);
            phase_end = n_items + PHASE_ITEMS;
            while (n_items < phase_end && n_items < TARGET_ITEMS) random_cmd();
            phase++;
        end

        cmd_if.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.outstanding() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (sb.n_errors == 0 && sb.outstanding() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ===== scsi_target_cdb_decoder_top.f =====
hdl/stcd_pkg.sv
hdl/stcd_in_if.sv
hdl/stcd_out_if.sv
hdl/stcd_collect.sv
hdl/stcd_decode.sv
hdl/scsi_target_cdb_decoder_top.sv
hdl/stcd_checker.sv
sim/scsi_target_cdb_decoder_top_tb.sv
